>>> hw/rtl/bitmap_texture_sampler_top_defines.svh
// Assertion macros used by the sampler checker.
`ifndef BITMAP_TEXTURE_SAMPLER_TOP_DEFINES_SVH
`define BITMAP_TEXTURE_SAMPLER_TOP_DEFINES_SVH

// Check that cons holds whenever ante holds.
`define BTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bts: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bts: next-cycle check failed");

`endif

>>> hw/rtl/bts_pkg.sv
// Types and constants of the bitmap texture sampler.
`default_nettype none

package bts_pkg;

    localparam int COORD_W   = 12;
    localparam int COUNT_W   = 7;
    localparam int PIX_W     = 32;
    localparam int MAT_W     = 32;
    localparam int ADDR_W    = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int CFG_IDX_W = 3;
    localparam int TILE_W    = 2;
    localparam int ALPHA_W   = 9;
    localparam int P2_W      = 14;
    localparam int PROD_W    = MAT_W + P2_W + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FRAC_SH   = 17;
    localparam int T_W       = SUM_W - FRAC_SH;
    localparam int TP_W      = 31;
    localparam int CRD_W     = 12;
    localparam int NUM_MAT   = 6;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

    localparam logic MODE_SPAN = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_M_XX,
        CFG_M_XY,
        CFG_M_X0,
        CFG_M_YX,
        CFG_M_YY,
        CFG_M_Y0,
        CFG_TILE_MODE,
        CFG_ALPHA_SCALE
    } cfg_idx_t;

    typedef enum logic [TILE_W-1:0] {
        TILE_CLAMP,
        TILE_REPEAT,
        TILE_MIRROR
    } tile_t;

    typedef struct packed {
        logic valid;
        logic load;
        logic last;
    } ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_texture_sampler_top.sv
// Nearest-neighbor bitmap texture sampler: span sequencer, affine map, tiling, fetch, opacity.
`default_nettype none

// A span request of count pixels holds the input while its pixels are issued: the span
// sequencer issues one pixel per cycle unless the output stalls, and takes the next
// request in the cycle after it issues the last pixel. A texel load is a single item
// that travels down the same pipeline, so loads and samples reach the texture memory
// in request order. Each pixel passes ten register stages (sequencer, matrix products,
// sums, offset and clamp, reciprocal multiply, remainder, tiling, address, memory
// read, opacity); the last of them is the output register. A stall on the output
// freezes the whole pipeline, including the input side. The texture memory has no
// clearing pass; texels read before being loaded are undefined.
module bitmap_texture_sampler_top #(
    parameter int TEX_WIDTH  = 64,
    parameter int TEX_HEIGHT = 64,
    parameter int MAX_SPAN   = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bts_pkg::MAT_W-1:0]       cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            mode,
    input  wire logic [bts_pkg::COORD_W-1:0]     span_x,
    input  wire logic [bts_pkg::COORD_W-1:0]     span_y,
    input  wire logic [bts_pkg::COUNT_W-1:0]     span_count,
    input  wire logic [bts_pkg::ADDR_W-1:0]      texel_index,
    input  wire logic [bts_pkg::PIX_W-1:0]       texel_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [bts_pkg::PIX_W-1:0]            pixel_argb,
    output logic                                 last_in_span
);
    import bts_pkg::*;

    localparam int NSTG = 9;

    logic signed [MAT_W-1:0]   mat_reg [NUM_MAT];
    tile_t                     tile_mode_reg;
    logic [ALPHA_W-1:0]        alpha_reg;

    logic                      adv;
    logic                      accept;
    logic [COUNT_W-1:0]        span_cnt;

    logic                      busy_reg, busy_next;
    logic [COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [P2_W-1:0]           cur_reg, cur_next;
    logic [P2_W-1:0]           py2_reg, py2_next;
    ctl_t                      c1_next;
    logic [P2_W-1:0]           px2_1_next;

    ctl_t                      c_reg [1:NSTG];
    logic [P2_W-1:0]           px2_1_reg;
    logic [P2_W-1:0]           py2_1_reg;
    logic [ADDR_W-1:0]         ldi_reg [1:7];
    logic [PIX_W-1:0]          ldv_reg [1:8];

    logic [CRD_W-1:0]          crd_reg [2];
    logic [2*CRD_W-1:0]        addr_full;
    logic [ADDR_W-1:0]         addr_reg;

    logic [PIX_W-1:0]          tex_mem [STORE_DEPTH];
    logic [PIX_W-1:0]          rd_reg;

    logic [ALPHA_W-1:0]        alpha_sat;
    logic [PIX_W-1:0]          scaled;

    logic                      out_valid_reg;
    logic [PIX_W-1:0]          pixel_reg;
    logic                      last_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg || !adv;
    assign accept   = in_valid && !in_stall;
    assign span_cnt = (span_count > COUNT_W'(MAX_SPAN)) ? COUNT_W'(MAX_SPAN) : span_count;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[0]    <= 32'sd65536;
            mat_reg[1]    <= '0;
            mat_reg[2]    <= '0;
            mat_reg[3]    <= '0;
            mat_reg[4]    <= 32'sd65536;
            mat_reg[5]    <= '0;
            tile_mode_reg <= TILE_CLAMP;
            alpha_reg     <= ALPHA_FULL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index)) inside
                CFG_M_XX, CFG_M_XY, CFG_M_X0, CFG_M_YX, CFG_M_YY, CFG_M_Y0:
                begin
                    mat_reg[cfg_index] <= $signed(cfg_data);
                end
                CFG_TILE_MODE:
                begin
                    tile_mode_reg <= tile_t'(cfg_data[TILE_W-1:0]);
                end
                CFG_ALPHA_SCALE:
                begin
                    alpha_reg <= cfg_data[ALPHA_W-1:0];
                end
            endcase
        end
    end

    // Span sequencer: issue one pixel per cycle while the output does not stall.
    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        cur_next   = cur_reg;
        py2_next   = py2_reg;
        c1_next    = '0;
        px2_1_next = cur_reg;
        if (busy_reg)
        begin
            c1_next.valid = 1'b1;
            c1_next.last  = (cnt_reg == COUNT_W'(1));
            busy_next     = (cnt_reg != COUNT_W'(1));
            cnt_next      = cnt_reg - COUNT_W'(1);
            cur_next      = cur_reg + P2_W'(2);
        end
        else if (accept)
        begin
            if (mode == MODE_LOAD)
            begin
                c1_next.valid = 1'b1;
                c1_next.load  = 1'b1;
            end
            else if (span_cnt != '0)
            begin
                c1_next.valid = 1'b1;
                c1_next.last  = (span_cnt == COUNT_W'(1));
                px2_1_next    = {1'b0, span_x, 1'b1};
                py2_next      = {1'b0, span_y, 1'b1};
                cur_next      = {1'b0, span_x, 1'b1} + P2_W'(2);
                cnt_next      = span_cnt - COUNT_W'(1);
                busy_next     = (span_cnt > COUNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int k = 1; k <= NSTG; k++)
            begin
                c_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            c_reg[1] <= c1_next;
            for (int k = 2; k <= NSTG; k++)
            begin
                c_reg[k] <= c_reg[k-1];
            end
            out_valid_reg <= c_reg[NSTG].valid && !c_reg[NSTG].load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cur_reg    <= cur_next;
            py2_reg    <= py2_next;
            px2_1_reg  <= px2_1_next;
            py2_1_reg  <= busy_reg ? py2_reg : py2_next;
            ldi_reg[1] <= texel_index;
            ldv_reg[1] <= texel_value;
            for (int k = 2; k <= 7; k++)
            begin
                ldi_reg[k] <= ldi_reg[k-1];
            end
            for (int k = 2; k <= 8; k++)
            begin
                ldv_reg[k] <= ldv_reg[k-1];
            end
        end
    end

    // Per-axis map, floor and tiling.
    for (genvar a = 0; a < 2; a++)
    begin : g_axis
        localparam int    N    = (a == 0) ? TEX_WIDTH : TEX_HEIGHT;
        localparam int    N2   = 2 * N;
        localparam int    R_W  = $clog2(2 * N2);
        localparam longint OFF = longint'(N2) * (((longint'(1) << 30) + N2 - 1) / N2);
        localparam longint RF  = (longint'(1) << TP_W) / N2;
        localparam logic [TP_W:0]   OFF_V = (TP_W + 1)'(OFF);
        localparam logic [TP_W-1:0] RF_V  = TP_W'(RF);
        localparam logic [TP_W-1:0] N2_V  = TP_W'(N2);
        localparam logic [R_W-1:0]  NR    = R_W'(N);
        localparam logic [R_W-1:0]  N2R   = R_W'(N2);

        logic signed [PROD_W-1:0] pa_reg, pb_reg;
        logic signed [SUM_W-1:0]  sum;
        logic signed [T_W-1:0]    t_reg;
        logic [TP_W:0]            tp;
        logic [TP_W-1:0]          tp4_reg, tp5_reg;
        logic [CRD_W-1:0]         clp4_reg, clp5_reg, clp6_reg;
        logic [2*TP_W-1:0]        qprod;
        logic [TP_W-1:0]          q_reg;
        logic [TP_W-1:0]          qn;
        logic [TP_W-1:0]          r_full;
        logic [R_W-1:0]           r_reg;
        logic [R_W-1:0]           m2;
        logic [R_W-1:0]           crd;

        assign sum = SUM_W'(pa_reg) + SUM_W'(pb_reg)
                   + SUM_W'($signed({mat_reg[3*a+2], 1'b0}));
        assign tp  = (TP_W + 1)'($signed(t_reg)) + OFF_V;
        assign qprod  = (2*TP_W)'(tp4_reg) * (2*TP_W)'(RF_V);
        assign qn     = q_reg * N2_V;
        assign r_full = tp5_reg - qn;
        assign m2     = (r_reg >= N2R) ? r_reg - N2R : r_reg;

        always_comb
        begin
            case (tile_mode_reg)
                TILE_CLAMP:
                begin
                    crd = R_W'(clp6_reg);
                end
                TILE_REPEAT:
                begin
                    crd = (m2 >= NR) ? m2 - NR : m2;
                end
                default:
                begin
                    crd = (m2 >= NR) ? N2R - R_W'(1) - m2 : m2;
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                pa_reg <= mat_reg[3*a]   * $signed({1'b0, px2_1_reg});
                pb_reg <= mat_reg[3*a+1] * $signed({1'b0, py2_1_reg});
                t_reg  <= sum[SUM_W-1:FRAC_SH];
                tp4_reg <= tp[TP_W-1:0];
                if (t_reg[T_W-1])
                begin
                    clp4_reg <= '0;
                end
                else if ($unsigned(t_reg) > T_W'(N - 1))
                begin
                    clp4_reg <= CRD_W'(N - 1);
                end
                else
                begin
                    clp4_reg <= t_reg[CRD_W-1:0];
                end
                q_reg    <= qprod[2*TP_W-1:TP_W];
                tp5_reg  <= tp4_reg;
                clp5_reg <= clp4_reg;
                r_reg    <= r_full[R_W-1:0];
                clp6_reg <= clp5_reg;
                crd_reg[a] <= CRD_W'(crd);
            end
        end
    end

    assign addr_full = {{CRD_W{1'b0}}, crd_reg[1]} * (2*CRD_W)'(TEX_WIDTH)
                     + (2*CRD_W)'(crd_reg[0]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg <= c_reg[7].load ? ldi_reg[7] : addr_full[ADDR_W-1:0];
        end
    end

    // Texture memory: write on load, read on sample.
    always_ff @(posedge clk)
    begin
        if (adv && c_reg[8].valid)
        begin
            if (c_reg[8].load)
            begin
                tex_mem[addr_reg] <= ldv_reg[8];
            end
            else
            begin
                rd_reg <= tex_mem[addr_reg];
            end
        end
    end

    assign alpha_sat = (alpha_reg > ALPHA_FULL) ? ALPHA_FULL : alpha_reg;

    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            scaled[8*b +: 8] = 8'((17'(rd_reg[8*b +: 8]) * 17'(alpha_sat)) >> 8);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pixel_reg <= scaled;
            last_reg  <= c_reg[NSTG].last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_argb   = pixel_reg;
    assign last_in_span = last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bts_checker.sv
// Port-level checker for the sampler and its bind.
`default_nettype none
`include "bitmap_texture_sampler_top_defines.svh"

module bts_checker #(
    parameter int MAX_SPAN = 64
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          mode,
    input wire logic [bts_pkg::COUNT_W-1:0]   span_count,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [bts_pkg::PIX_W-1:0]     pixel_argb,
    input wire logic                          last_in_span
);
    import bts_pkg::*;

    logic long_span_accept;

    assign long_span_accept = in_valid && !in_stall && (mode == MODE_SPAN)
                           && (span_count > COUNT_W'(1)) && (MAX_SPAN > 1);

    `BTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pixel_argb) && $stable(last_in_span))
    `BTS_ASSERT_IMPL(a_frozen_input, clk, rst_n, out_valid && out_stall, in_stall)
    `BTS_ASSERT_NEXT(a_span_busy, clk, rst_n, long_span_accept, in_stall)

endmodule

bind bitmap_texture_sampler_top bts_checker #(.MAX_SPAN(MAX_SPAN)) u_bts_checker (.*);

`default_nettype wire
